@@ hdl/afr_pkg.sv @@
// Shared constants, codes and the arctangent table for the alt/az frame rotation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COEFF_BITS_DEF = 18;

    localparam int CORDIC_ITERS = 24;
    localparam int TURN_BITS    = 32;   // internal binary angle, full turn = 2^32
    localparam int VAL_W        = 32;   // Q.30 sine/cosine after quadrant fold
    localparam int ROT_W        = 34;   // rotation CORDIC datapath
    localparam int VEC_W        = 42;   // vectoring CORDIC datapath
    localparam int ACC_W        = 34;   // angle accumulator
    localparam int INV_GAIN_Q30 = 652032874;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    typedef enum logic [1:0] {
        REG_ROW_ZERO = 2'd0,
        REG_ROW_ONE  = 2'd1,
        REG_ROW_TWO  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        QUAD_E = 2'd0,
        QUAD_N = 2'd1,
        QUAD_W = 2'd2,
        QUAD_S = 2'd3
    } quad_t;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [TURN_BITS-1:0] atan_turn(input int i);
        logic [TURN_BITS-1:0] v;
        case (i)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/afr_if.sv @@
// Request and result channel interfaces for the alt/az frame rotation.
// Depends on afr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface afr_coord_in_if
    import afr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [ANGLE_BITS-1:0] alt_in;
    logic        [ANGLE_BITS-1:0] az_in;

    modport source (output valid, kind, alt_in, az_in, input ready);
    modport sink   (input valid, kind, alt_in, az_in, output ready);
endinterface

interface afr_coord_out_if
    import afr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] alt_out;
    logic        [ANGLE_BITS-1:0] az_out;

    modport source (output valid, alt_out, az_out, input ready);
    modport sink   (input valid, alt_out, az_out, output ready);
endinterface

`default_nettype wire

@@ hdl/altaz_frame_rotation_top.sv @@
// Alt/az frame rotation: top level with the APB register file and matrix stages.
// Depends on afr_pkg, afr_if, afr_sincos and afr_vector.
//
// Usage:
//   coord_in carries one request (kind, alt_in, az_in); coord_out returns one
//   result (alt_out, az_out) per request, in request order. Both channels use
//   valid/ready; a transfer happens when both are high.
//   kind 0 rotates by the matrix (mount to sky), kind 1 by its transpose.
//   The matrix rows are written over APB at 0x00, 0x08, 0x10 (64-bit data,
//   three packed signed Q2.16 coefficients per row). Write only while idle.
//   From request to result: 25 stages of sine/cosine CORDIC, three matrix
//   stages, 25 stages of azimuth vectoring, one gain correction multiply,
//   25 stages of altitude vectoring, one output stage. Throughput is one
//   request per cycle unless stalled; the pipeline is fully stage-registered.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline freezes and ready on coord_in drops; nothing is lost or repeated.
//   Reset empties the pipeline and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none

module altaz_frame_rotation_top
    import afr_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COEFF_BITS = COEFF_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    afr_coord_in_if.sink              coord_in,
    afr_coord_out_if.source           coord_out,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    localparam int ROW_W   = 3 * COEFF_BITS;
    localparam int FRAC    = COEFF_BITS - 2;
    localparam int PROD_W  = COEFF_BITS + ROT_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int ASHIFT  = TURN_BITS - ANGLE_BITS;
    localparam int MPROD_W = 64;

    localparam logic [ROW_W-1:0] ROW_ZERO_RST = ROW_W'(1) << FRAC;
    localparam logic [ROW_W-1:0] ROW_ONE_RST  = ROW_W'(1) << (FRAC + COEFF_BITS);
    localparam logic [ROW_W-1:0] ROW_TWO_RST  = ROW_W'(1) << (FRAC + 2 * COEFF_BITS);
    localparam logic [TURN_BITS-1:0] HALF_LSB = TURN_BITS'(1) << (ASHIFT - 1);
    localparam logic signed [ACC_W-1:0] ALT_LIM = ACC_W'(1) << (ANGLE_BITS - 2);

    // ---------------- register file ----------------
    logic [ROW_W-1:0] row0_reg;
    logic [ROW_W-1:0] row1_reg;
    logic [ROW_W-1:0] row2_reg;
    logic             wr_en;
    reg_idx_t         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= ROW_ZERO_RST;
            row1_reg <= ROW_ONE_RST;
            row2_reg <= ROW_TWO_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ROW_ZERO: row0_reg <= pwdata[ROW_W-1:0];
                REG_ROW_ONE:  row1_reg <= pwdata[ROW_W-1:0];
                REG_ROW_TWO:  row2_reg <= pwdata[ROW_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ROW_ZERO: prdata = PDATA_W'(row0_reg);
            REG_ROW_ONE:  prdata = PDATA_W'(row1_reg);
            REG_ROW_TWO:  prdata = PDATA_W'(row2_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic out_valid_reg;
    logic adv;

    assign adv            = !out_valid_reg || coord_out.ready;
    assign coord_in.ready = adv;

    // ---------------- sine / cosine ----------------
    logic [TURN_BITS-1:0]    theta [2];
    logic                    sc_valid;
    logic                    sc_kind;
    logic signed [VAL_W-1:0] sc_cos [2];
    logic signed [VAL_W-1:0] sc_sin [2];

    assign theta[0] = {coord_in.alt_in, {ASHIFT{1'b0}}};
    assign theta[1] = {coord_in.az_in, {ASHIFT{1'b0}}};

    afr_sincos #(
        .SIDE_W (1)
    ) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (coord_in.valid),
        .in_side   (coord_in.kind),
        .theta     (theta),
        .out_valid (sc_valid),
        .out_side  (sc_kind),
        .cos_out   (sc_cos),
        .sin_out   (sc_sin)
    );

    // ---------------- unit vector ----------------
    logic                    m1_valid_reg;
    logic                    m1_kind_reg;
    logic signed [ROT_W-1:0] v_reg [3];
    logic signed [2*VAL_W-1:0] pxc;
    logic signed [2*VAL_W-1:0] pxs;

    assign pxc = sc_cos[0] * sc_cos[1];
    assign pxs = sc_cos[0] * sc_sin[1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_kind_reg <= sc_kind;
            v_reg[0]    <= ROT_W'(pxc >>> 30);
            v_reg[1]    <= ROT_W'(pxs >>> 30);
            v_reg[2]    <= ROT_W'(sc_sin[0]);
        end
    end

    // ---------------- matrix products ----------------
    logic [ROW_W-1:0]         rows [3];
    logic signed [COEFF_BITS-1:0] coef [3][3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic                     m2_valid_reg;

    assign rows[0] = row0_reg;
    assign rows[1] = row1_reg;
    assign rows[2] = row2_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (m1_kind_reg)
                    coef[k][j] = signed'(rows[j][k*COEFF_BITS +: COEFF_BITS]);
                else
                    coef[k][j] = signed'(rows[k][j*COEFF_BITS +: COEFF_BITS]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[k][j] <= PROD_W'(coef[k][j] * v_reg[j]);
                end
            end
        end
    end

    // ---------------- matrix sums ----------------
    logic                    m3_valid_reg;
    logic signed [VEC_W-1:0] w_reg [3];
    logic signed [SUM_W-1:0] wsum [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wsum[k] = SUM_W'(prod_reg[k][0]) + SUM_W'(prod_reg[k][1])
                    + SUM_W'(prod_reg[k][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                w_reg[k] <= VEC_W'(wsum[k] >>> FRAC);
            end
        end
    end

    // ---------------- azimuth vectoring ----------------
    logic                    az_valid;
    logic [VEC_W-1:0]        az_side;
    logic signed [ACC_W-1:0] az_angle;
    logic signed [VEC_W-1:0] az_mag;

    afr_vector #(
        .SIDE_W (VEC_W)
    ) u_vec_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m3_valid_reg),
        .in_side   (w_reg[2]),
        .x_in      (w_reg[0]),
        .y_in      (w_reg[1]),
        .out_valid (az_valid),
        .out_side  (az_side),
        .angle     (az_angle),
        .mag       (az_mag)
    );

    // ---------------- azimuth rounding, planar gain correction ----------------
    logic                      r1_valid_reg;
    logic [ANGLE_BITS-1:0]     az_q_reg;
    logic signed [VEC_W-1:0]   z_reg;
    logic signed [MPROD_W-1:0] mprod_reg;
    logic [TURN_BITS-1:0]      az_round;
    logic [TURN_BITS-1:0]      mag_q;

    assign az_round = TURN_BITS'(az_angle) + HALF_LSB;
    assign mag_q    = TURN_BITS'(az_mag >>> 2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            az_q_reg  <= az_round[TURN_BITS-1 -: ANGLE_BITS];
            z_reg     <= signed'(az_side);
            mprod_reg <= signed'({1'b0, mag_q}) * signed'({1'b0, 30'(INV_GAIN_Q30)});
        end
    end

    // ---------------- altitude vectoring ----------------
    logic                    alt_valid;
    logic [ANGLE_BITS-1:0]   alt_side;
    logic signed [ACC_W-1:0] alt_angle;
    logic signed [VEC_W-1:0] alt_mag;
    logic signed [VEC_W-1:0] r_planar;

    assign r_planar = VEC_W'(mprod_reg >>> 28);

    afr_vector #(
        .SIDE_W (ANGLE_BITS)
    ) u_vec_alt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (r1_valid_reg),
        .in_side   (az_q_reg),
        .x_in      (r_planar),
        .y_in      (z_reg),
        .out_valid (alt_valid),
        .out_side  (alt_side),
        .angle     (alt_angle),
        .mag       (alt_mag)
    );

    // ---------------- output stage ----------------
    logic signed [ACC_W-1:0]      alt_v;
    logic signed [ACC_W-1:0]      alt_c;
    logic signed [ANGLE_BITS-1:0] alt_out_reg;
    logic [ANGLE_BITS-1:0]        az_out_reg;
    logic                         alt_mag_pos;

    // length from the second pass has no use beyond a sanity bit
    assign alt_mag_pos = !alt_mag[VEC_W-1];

    assign alt_v = (alt_angle + signed'(ACC_W'(HALF_LSB))) >>> ASHIFT;

    always_comb
    begin
        if (alt_v > ALT_LIM)
            alt_c = ALT_LIM;
        else if (alt_v < -ALT_LIM)
            alt_c = -ALT_LIM;
        else
            alt_c = alt_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alt_out_reg <= alt_mag_pos ? ANGLE_BITS'(alt_c) : ANGLE_BITS'(alt_c);
            az_out_reg  <= alt_side;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg  <= sc_valid;
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            r1_valid_reg  <= az_valid;
            out_valid_reg <= alt_valid;
        end
    end

    assign coord_out.valid   = out_valid_reg;
    assign coord_out.alt_out = alt_out_reg;
    assign coord_out.az_out  = az_out_reg;

endmodule

`default_nettype wire

@@ hdl/afr_sincos.sv @@
// Two-lane pipelined rotation CORDIC: cosine and sine of two binary angles.
// One register stage per iteration plus an input stage. Depends on afr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afr_sincos
    import afr_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [SIDE_W-1:0]       in_side,
    input  wire logic [TURN_BITS-1:0]    theta [2],
    output logic                         out_valid,
    output logic      [SIDE_W-1:0]       out_side,
    output logic signed [VAL_W-1:0]      cos_out [2],
    output logic signed [VAL_W-1:0]      sin_out [2]
);

    logic                    valid_reg [0:CORDIC_ITERS];
    logic [SIDE_W-1:0]       side_reg  [0:CORDIC_ITERS];
    logic signed [ROT_W-1:0] x_reg     [0:CORDIC_ITERS][0:1];
    logic signed [ROT_W-1:0] y_reg     [0:CORDIC_ITERS][0:1];
    logic signed [ROT_W-1:0] r_reg     [0:CORDIC_ITERS][0:1];
    logic [1:0]              q_reg     [0:CORDIC_ITERS][0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_ITERS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= CORDIC_ITERS; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i <= CORDIC_ITERS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_ITERS];
    assign out_side  = side_reg[CORDIC_ITERS];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [TURN_BITS-1:0] bias_sum;
        logic [TURN_BITS-1:0] resid;

        // fold into [-45, 45) degrees around the nearest axis
        assign bias_sum = theta[l] + (TURN_BITS'(1) << (TURN_BITS - 3));
        assign resid    = theta[l] - {bias_sum[TURN_BITS-1 -: 2], {(TURN_BITS-2){1'b0}}};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[0][l] <= ROT_W'(INV_GAIN_Q30);
                y_reg[0][l] <= '0;
                r_reg[0][l] <= ROT_W'(signed'(resid));
                q_reg[0][l] <= bias_sum[TURN_BITS-1 -: 2];
            end
        end

        for (genvar i = 0; i < CORDIC_ITERS; i++)
        begin : g_iter
            logic signed [ROT_W-1:0] xs;
            logic signed [ROT_W-1:0] ys;
            logic signed [ROT_W-1:0] at;

            assign xs = x_reg[i][l] >>> i;
            assign ys = y_reg[i][l] >>> i;
            assign at = signed'(ROT_W'(atan_turn(i)));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[i+1][l] <= q_reg[i][l];
                    if (!r_reg[i][l][ROT_W-1])
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - ys;
                        y_reg[i+1][l] <= y_reg[i][l] + xs;
                        r_reg[i+1][l] <= r_reg[i][l] - at;
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + ys;
                        y_reg[i+1][l] <= y_reg[i][l] - xs;
                        r_reg[i+1][l] <= r_reg[i][l] + at;
                    end
                end
            end
        end

        logic signed [ROT_W-1:0] xf;
        logic signed [ROT_W-1:0] yf;
        logic signed [ROT_W-1:0] c_full;
        logic signed [ROT_W-1:0] s_full;

        assign xf = x_reg[CORDIC_ITERS][l];
        assign yf = y_reg[CORDIC_ITERS][l];

        always_comb
        begin
            case (quad_t'(q_reg[CORDIC_ITERS][l]))
                QUAD_E:
                begin
                    c_full = xf;
                    s_full = yf;
                end
                QUAD_N:
                begin
                    c_full = -yf;
                    s_full = xf;
                end
                QUAD_W:
                begin
                    c_full = -xf;
                    s_full = -yf;
                end
                default:
                begin
                    c_full = yf;
                    s_full = -xf;
                end
            endcase
        end

        assign cos_out[l] = VAL_W'(c_full);
        assign sin_out[l] = VAL_W'(s_full);
    end

endmodule

`default_nettype wire

@@ hdl/afr_vector.sv @@
// Pipelined vectoring CORDIC: angle and gain-scaled length of (x, y).
// Input stage, one register stage per iteration. Depends on afr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afr_vector
    import afr_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic [SIDE_W-1:0]       in_side,
    input  wire logic signed [VEC_W-1:0] x_in,
    input  wire logic signed [VEC_W-1:0] y_in,
    output logic                         out_valid,
    output logic      [SIDE_W-1:0]       out_side,
    output logic signed [ACC_W-1:0]      angle,
    output logic signed [VEC_W-1:0]      mag
);

    localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(64'd1 << (TURN_BITS - 1));

    logic                    valid_reg [0:CORDIC_ITERS];
    logic [SIDE_W-1:0]       side_reg  [0:CORDIC_ITERS];
    logic                    zero_reg  [0:CORDIC_ITERS];
    logic signed [VEC_W-1:0] x_reg     [0:CORDIC_ITERS];
    logic signed [VEC_W-1:0] y_reg     [0:CORDIC_ITERS];
    logic signed [ACC_W-1:0] acc_reg   [0:CORDIC_ITERS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_ITERS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= CORDIC_ITERS; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // left half-plane: mirror through the origin and start from half a turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[VEC_W-1])
            begin
                x_reg[0]   <= -x_in;
                y_reg[0]   <= -y_in;
                acc_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0]   <= x_in;
                y_reg[0]   <= y_in;
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [ACC_W-1:0] at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = signed'(ACC_W'(atan_turn(i)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                if (!y_reg[i][VEC_W-1])
                begin
                    x_reg[i+1]   <= x_reg[i] + ys;
                    y_reg[i+1]   <= y_reg[i] - xs;
                    acc_reg[i+1] <= acc_reg[i] + at;
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] - ys;
                    y_reg[i+1]   <= y_reg[i] + xs;
                    acc_reg[i+1] <= acc_reg[i] - at;
                end
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_ITERS];
    assign out_side  = side_reg[CORDIC_ITERS];
    assign angle     = zero_reg[CORDIC_ITERS] ? '0 : acc_reg[CORDIC_ITERS];
    assign mag       = zero_reg[CORDIC_ITERS] ? '0 : x_reg[CORDIC_ITERS];

endmodule

`default_nettype wire
